// ===== design/ptsi_pkg.sv =====
package ptsi_pkg;

	// datapath widths
	localparam int MAX_RANK  = 4;
	localparam int DIM_BITS  = 16;
	localparam int IDX_W     = 32;
	localparam int PAGE_W    = 32;
	localparam int RANK_W    = 3;
	localparam int ORDER_W   = 2;
	localparam int SIZE_FLD  = 16;
	localparam int STRIDE_W  = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// divider pipeline shape: quotient bits retired per stage
	localparam int STEPS_PER_STAGE = 2;
	localparam int STAGES_PER_DIM  = IDX_W / STEPS_PER_STAGE;
	localparam int DIV_STAGES      = MAX_RANK * STAGES_PER_DIM;

	// register reset values
	localparam logic [RANK_W-1:0] RANK_RST  = RANK_W'(1);
	localparam logic [CFG_W-1:0]  SIZES_RST = 64'h0001_0001_0001_0001;
	localparam logic [7:0]        ORDER_RST = 8'hE4;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK       = 3'd0,
		REG_DIM_SIZES  = 3'd1,
		REG_INV_ORDER  = 3'd2,
		REG_STRIDES_LO = 3'd3,
		REG_STRIDES_HI = 3'd4
	} cfg_reg_t;

	// one coordinate per dimension
	typedef logic [MAX_RANK-1:0][DIM_BITS-1:0] crd_t;

endpackage

// ===== design/permuted_tile_source_index_top.sv =====
// Permuted tile source index.
// Maps a linear output tile index of a permuted tensor to the source page
// that holds the same tile. The index is split in mixed radix over the
// configured sizes (highest used dimension fastest), coordinates are gathered
// through the inverse permutation and dotted with the source strides mod 2^32.
// Input channel: in_valid / in_stall with tile_index. Output channel:
// out_valid / out_stall with source_page. A word moves at a rising edge with
// valid high and stall low. Configuration: cfg_we, cfg_index, cfg_data; write
// only while no word is in flight.
// The pipeline has 64 restoring divider stages (two quotient bits per
// stage, sixteen stages per dimension, four dimensions), one multiply
// stage, one add stage and the output register. Throughput is one word
// per cycle while the output is not stalled. When the receiver stalls a
// valid output, the whole pipeline holds and in_stall rises in the same
// cycle; nothing is dropped or repeated. Reset clears all valid bits and
// loads rank 1, sizes 1, identity order and zero strides.
module permuted_tile_source_index_top import ptsi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [IDX_W-1:0]     tile_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PAGE_W-1:0]    source_page
);

	logic [RANK_W-1:0] rank_q;
	logic [CFG_W-1:0]  dim_sizes_q;
	logic [7:0]        inv_order_q;
	logic [CFG_W-1:0]  strides_lo_q;
	logic [CFG_W-1:0]  strides_hi_q;

	logic [RANK_W-1:0]   rank_eff;
	logic [DIM_BITS-1:0] div_sz [MAX_RANK];
	logic [2*CFG_W-1:0]  stride_all;
	logic                adv;

	logic [IDX_W-1:0]    quo_s [DIV_STAGES];
	logic [DIM_BITS-1:0] rem_s [DIV_STAGES];
	crd_t                crd_s [DIV_STAGES];
	logic                vld_s [DIV_STAGES];

	logic [PAGE_W-1:0] prod_sm [MAX_RANK];
	logic              vld_sm;
	logic [PAGE_W-1:0] sum_lo_sa;
	logic [PAGE_W-1:0] sum_hi_sa;
	logic              vld_sa;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q       <= RANK_RST;
			dim_sizes_q  <= SIZES_RST;
			inv_order_q  <= ORDER_RST;
			strides_lo_q <= '0;
			strides_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RANK:       rank_q       <= cfg_data[RANK_W-1:0];
				REG_DIM_SIZES:  dim_sizes_q  <= cfg_data;
				REG_INV_ORDER:  inv_order_q  <= cfg_data[7:0];
				REG_STRIDES_LO: strides_lo_q <= cfg_data;
				REG_STRIDES_HI: strides_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp rank to 1..MAX_RANK
	always_comb begin
		if (rank_q == '0)
			rank_eff = RANK_W'(1);
		else if (rank_q > RANK_W'(MAX_RANK))
			rank_eff = RANK_W'(MAX_RANK);
		else
			rank_eff = rank_q;
	end

	// effective divisors: zero or unused dimensions divide by one
	always_comb begin
		for (int d = 0; d < MAX_RANK; d++) begin
			if (RANK_W'(d) < rank_eff && dim_sizes_q[SIZE_FLD*d +: DIM_BITS] != '0)
				div_sz[d] = dim_sizes_q[SIZE_FLD*d +: DIM_BITS];
			else
				div_sz[d] = DIM_BITS'(1);
		end
	end

	assign stride_all = {strides_hi_q, strides_lo_q};

	// global advance: the pipeline moves unless a valid output is stalled
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// divider pipeline, dimension MAX_RANK-1 first
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int  DIM   = MAX_RANK - 1 - k / STAGES_PER_DIM;
		localparam bit  FIRST = (k % STAGES_PER_DIM) == 0;
		localparam bit  LAST  = (k % STAGES_PER_DIM) == STAGES_PER_DIM - 1;

		logic [IDX_W-1:0]    src_quo;
		logic [DIM_BITS-1:0] src_rem;
		crd_t                src_crd;
		logic                src_vld;
		logic [IDX_W-1:0]    nx_quo;
		logic [DIM_BITS-1:0] nx_rem;
		crd_t                nx_crd;
		logic [DIM_BITS:0]   part;

		if (k == 0) begin : g_src
			assign src_quo = tile_index;
			assign src_rem = '0;
			assign src_crd = '0;
			assign src_vld = in_valid;
		end else begin : g_src
			assign src_quo = quo_s[k-1];
			assign src_rem = rem_s[k-1];
			assign src_crd = crd_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		// two restoring steps; quotient bits shift in as dividend bits shift out
		always_comb begin
			nx_quo = src_quo;
			nx_rem = FIRST ? '0 : src_rem;
			nx_crd = src_crd;
			part   = '0;
			for (int b = 0; b < STEPS_PER_STAGE; b++) begin
				part   = {nx_rem, nx_quo[IDX_W-1]};
				nx_quo = {nx_quo[IDX_W-2:0], 1'b0};
				if (part >= {1'b0, div_sz[DIM]}) begin
					nx_rem    = DIM_BITS'(part - {1'b0, div_sz[DIM]});
					nx_quo[0] = 1'b1;
				end else begin
					nx_rem = part[DIM_BITS-1:0];
				end
			end
			if (LAST)
				nx_crd[DIM] = nx_rem;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv)
				vld_s[k] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k] <= nx_quo;
				rem_s[k] <= nx_rem;
				crd_s[k] <= nx_crd;
			end
		end
	end

	// multiply stage: gathered coordinate times stride, low bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sm <= 1'b0;
		else if (adv)
			vld_sm <= vld_s[DIV_STAGES-1];
	end

	for (genvar i = 0; i < MAX_RANK; i++) begin : g_mul
		logic [ORDER_W-1:0]           src;
		logic [DIM_BITS-1:0]          crd;
		logic [DIM_BITS+STRIDE_W-1:0] full;

		assign src  = inv_order_q[ORDER_W*i +: ORDER_W];
		assign crd  = (RANK_W'(src) < rank_eff) ? crd_s[DIV_STAGES-1][src] : '0;
		assign full = crd * stride_all[STRIDE_W*i +: STRIDE_W];

		always_ff @(posedge clk) begin
			if (adv) begin
				if (RANK_W'(i) < rank_eff)
					prod_sm[i] <= full[PAGE_W-1:0];
				else
					prod_sm[i] <= '0;
			end
		end
	end

	// add stage: two partial sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sa <= 1'b0;
		else if (adv)
			vld_sa <= vld_sm;
	end

	always_ff @(posedge clk) begin
		logic [PAGE_W-1:0] lo;
		logic [PAGE_W-1:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 0; i < MAX_RANK; i++) begin
			if (i < MAX_RANK / 2)
				lo = lo + prod_sm[i];
			else
				hi = hi + prod_sm[i];
		end
		if (adv) begin
			sum_lo_sa <= lo;
			sum_hi_sa <= hi;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= vld_sa;
	end

	always_ff @(posedge clk) begin
		if (adv)
			source_page <= sum_lo_sa + sum_hi_sa;
	end

endmodule

// ===== design/ptsi_checker.sv =====
module ptsi_checker import ptsi_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [PAGE_W-1:0]    source_page
);

	// a stalled output word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(source_page))
		else $error("output word changed while stalled");

	// the input is held back only by a stalled output word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a new output word appears only after the pipeline advanced
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("output word appeared while pipeline was held");

endmodule

bind permuted_tile_source_index_top ptsi_checker u_ptsi_checker (.*);

// ===== tb/tb_permuted_tile_source_index_top.sv =====
module tb_permuted_tile_source_index_top;
	import ptsi_pkg::*;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [IDX_W-1:0]     tile_index = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [PAGE_W-1:0]    source_page;

	// local copy of the configuration, starts at the reset values
	logic [RANK_W-1:0]  rank_q     = RANK_RST;
	logic [CFG_W-1:0]   sizes_q    = SIZES_RST;
	logic [7:0]         order_q    = ORDER_RST;
	logic [CFG_W-1:0]   strides_lo = '0;
	logic [CFG_W-1:0]   strides_hi = '0;

	logic [IDX_W-1:0]  tiles_to_send [$];
	logic [PAGE_W-1:0] pages_due [$];
	logic [PAGE_W-1:0] page_want;
	bit                failed = 1'b0;
	bit                steady = 1'b0;

	permuted_tile_source_index_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.tile_index  (tile_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.source_page (source_page)
	);

	// rank zero acts as one, anything above the maximum saturates
	function automatic int used_rank();
		if (rank_q == '0)
			return 1;
		if (rank_q > MAX_RANK)
			return MAX_RANK;
		return int'(rank_q);
	endfunction

	function automatic logic [IDX_W-1:0] dim_size(int d);
		logic [IDX_W-1:0] sz;
		sz = IDX_W'(sizes_q[SIZE_FLD*d +: DIM_BITS]);
		return (sz == '0) ? IDX_W'(1) : sz;
	endfunction

	// mixed-radix split, gather through the inverse order, dot with strides
	function automatic logic [PAGE_W-1:0] source_page_of(logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0]    rem;
		logic [IDX_W-1:0]    coord [MAX_RANK];
		logic [PAGE_W-1:0]   acc;
		logic [STRIDE_W-1:0] strd;
		logic [ORDER_W-1:0]  src;
		int                  r;
		int                  d;
		r   = used_rank();
		rem = idx;
		acc = '0;
		for (d = 0; d < MAX_RANK; d++)
			coord[d] = '0;
		for (d = r - 1; d >= 0; d--) begin
			coord[d] = rem % dim_size(d);
			rem      = rem / dim_size(d);
		end
		for (d = 0; d < r; d++) begin
			src  = order_q[ORDER_W*d +: ORDER_W];
			strd = (d < 2) ? strides_lo[STRIDE_W*(d % 2) +: STRIDE_W]
			               : strides_hi[STRIDE_W*(d % 2) +: STRIDE_W];
			if (int'(src) < r)
				acc = acc + PAGE_W'(coord[src] * strd);
		end
		return acc;
	endfunction

	// tile index biased toward the edges of the configured tensor
	function automatic logic [IDX_W-1:0] pick_tile();
		logic [63:0] span;
		int          d;
		span = 64'd1;
		for (d = 0; d < used_rank(); d++)
			span = span * 64'(dim_size(d));
		if (span > 64'h1_0000_0000)
			return $urandom;
		case ($urandom_range(0, 9))
			0: return IDX_W'(span - 1);
			1: return IDX_W'(span);
			2, 3: return $urandom;
			default: return $urandom_range(0, IDX_W'(span - 1));
		endcase
	endfunction

	// append one tile index to the pending words
	task automatic queue_tile(input logic [IDX_W-1:0] t);
		tiles_to_send.insert(tiles_to_send.size(), t);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_RANK:       rank_q     = val[RANK_W-1:0];
			REG_DIM_SIZES:  sizes_q    = val;
			REG_INV_ORDER:  order_q    = val[7:0];
			REG_STRIDES_LO: strides_lo = val;
			REG_STRIDES_HI: strides_hi = val;
			default: ;
		endcase
	endtask

	// only called with nothing in flight
	task automatic load_config(input logic [RANK_W-1:0] rk, input logic [CFG_W-1:0] sizes,
			input logic [7:0] ord, input logic [CFG_W-1:0] slo, input logic [CFG_W-1:0] shi);
		// index past the last register, must be ignored
		put_reg(CFG_IDX_W'(REG_STRIDES_HI + 1 + $urandom_range(0, 2)), {$urandom, $urandom});
		put_reg(REG_RANK, CFG_W'(rk));
		put_reg(REG_DIM_SIZES, sizes);
		put_reg(REG_INV_ORDER, CFG_W'(ord));
		put_reg(REG_STRIDES_LO, slo);
		put_reg(REG_STRIDES_HI, shi);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (tiles_to_send.size() != 0 || in_valid || pages_due.size() != 0);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// input driver: present the next word, predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				pages_due.insert(pages_due.size(), source_page_of(tile_index));
			if (!in_valid || !in_stall) begin
				if (tiles_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
					in_valid   <= 1'b1;
					tile_index <= tiles_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 38);
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pages_due.size() == 0) begin
				$display("%0t: unexpected word, source_page expected none actual %h",
					$time, source_page);
				failed = 1'b1;
			end else begin
				page_want = pages_due.pop_front();
				if (source_page !== page_want) begin
					$display("%0t: source_page expected %h actual %h",
						$time, page_want, source_page);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int                 ph;
		int                 n;
		int                 d;
		int                 j;
		logic [RANK_W-1:0]  rk;
		logic [CFG_W-1:0]   sizes_v;
		logic [7:0]         ord;
		logic [CFG_W-1:0]   slo;
		logic [CFG_W-1:0]   shi;
		logic [STRIDE_W-1:0] strd;
		logic [ORDER_W-1:0] perm [MAX_RANK];
		logic [ORDER_W-1:0] tmp;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: all strides zero
		queue_tile(32'h0000_0000);
		queue_tile(32'hFFFF_FFFF);
		drain();

		// full rank with a real permutation, leftover quotient above the top
		load_config(3'd4, {16'd11, 16'd7, 16'd5, 16'd3}, 8'h72,
			{32'h0000_0100, 32'h0000_0001}, {32'h0100_0000, 32'h0001_0000});
		queue_tile(32'd0);
		queue_tile(32'd1);
		queue_tile(32'd11);
		queue_tile(32'd1154);
		queue_tile(32'd1155);
		queue_tile(32'h8000_0000);
		queue_tile(32'hFFFF_FFFF);
		drain();

		// zero sizes act as one, maximum sizes and strides, rank saturates
		load_config(3'd7, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'h1B,
			{32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		queue_tile(32'hFFFF_FFFF);
		queue_tile(32'h1234_5678);
		queue_tile(32'h0000_FFFF);
		drain();

		// rank zero acts as rank one
		load_config(3'd0, {16'hABCD, 16'h1234, 16'h0000, 16'd9}, 8'hE4,
			{32'h5555_5555, 32'd7}, {32'hAAAA_AAAA, 32'h3333_3333});
		queue_tile(32'd5);
		queue_tile(32'hFFFF_FFFF);
		drain();

		// rank two, an order entry outside the rank, junk in unused dimensions
		load_config(3'd2, {16'h0F0F, 16'h7777, 16'd6, 16'd10}, 8'hC3,
			{32'd3, 32'hDEAD_BEEF}, {32'h1357_9BDF, 32'h2468_ACE0});
		queue_tile(32'd0);
		queue_tile(32'd59);
		queue_tile(32'd60);
		queue_tile(32'hFFFF_FFFF);
		drain();

		// random configurations, each with a batch of random words
		for (ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 9))
				0: rk = 3'd0;
				1: rk = RANK_W'($urandom_range(MAX_RANK + 1, 7));
				default: rk = RANK_W'($urandom_range(1, MAX_RANK));
			endcase
			for (d = 0; d < MAX_RANK; d++) begin
				case ($urandom_range(0, 9))
					0: sizes_v[SIZE_FLD*d +: SIZE_FLD] = '0;
					1: sizes_v[SIZE_FLD*d +: SIZE_FLD] = '1;
					2, 3: sizes_v[SIZE_FLD*d +: SIZE_FLD] = SIZE_FLD'($urandom);
					default: sizes_v[SIZE_FLD*d +: SIZE_FLD] = SIZE_FLD'($urandom_range(1, 12));
				endcase
			end
			if ($urandom_range(0, 9) < 7) begin
				for (d = 0; d < MAX_RANK; d++)
					perm[d] = ORDER_W'(d);
				for (d = MAX_RANK - 1; d > 0; d--) begin
					j       = $urandom_range(0, d);
					tmp     = perm[d];
					perm[d] = perm[j];
					perm[j] = tmp;
				end
				for (d = 0; d < MAX_RANK; d++)
					ord[ORDER_W*d +: ORDER_W] = perm[d];
			end else begin
				ord = 8'($urandom);
			end
			for (d = 0; d < MAX_RANK; d++) begin
				case ($urandom_range(0, 9))
					0: strd = '0;
					1: strd = '1;
					2, 3, 4: strd = $urandom;
					default: strd = STRIDE_W'($urandom_range(1, 4096));
				endcase
				if (d < 2)
					slo[STRIDE_W*d +: STRIDE_W] = strd;
				else
					shi[STRIDE_W*(d - 2) +: STRIDE_W] = strd;
			end
			load_config(rk, sizes_v, ord, slo, shi);
			// one batch runs with no idling on either side
			steady = (ph == 4);
			for (n = 0; n < 150; n++)
				queue_tile(pick_tile());
			drain();
		end
		steady = 1'b0;

		repeat (80) @(negedge clk);
		if (!failed && pages_due.size() == 0)
			$display("** permuted_tile_source_index_top: PASSED **");
		else
			$display("** permuted_tile_source_index_top: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("** permuted_tile_source_index_top: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ptsi_pkg.sv
design/permuted_tile_source_index_top.sv
design/ptsi_checker.sv
tb/tb_permuted_tile_source_index_top.sv
